// File: sv/multi_stack_shared_array_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the shared-array stack block.
// Each macro takes a label, the clock, the reset, an antecedent, a consequent and a message.
// ---------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_ARRAY_DEFINES_SVH
`define MULTI_STACK_SHARED_ARRAY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/msa_pkg.sv
// ---------------------------------------------------------------------------
// msa_pkg
// Types and constants shared by the shared-array stack block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

  // Field widths fixed by the item format.
  localparam int WORD_W     = 32;
  localparam int STK_W      = 5;
  localparam int NUM_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int MAX_STACKS = 32;

  // Operation codes.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_BASE,
    S_EXEC,
    S_OUT
  } msa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming item
    logic calc;    // work out segment bases and the current top
    logic exec;    // decide the status and touch the store
    logic cfg_wr;  // take a new stack count and empty every stack
  } msa_cmd_t;

endpackage

`default_nettype wire

// File: sv/msa_ram.sv
// ---------------------------------------------------------------------------
// msa_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/msa_ctrl.sv
// ---------------------------------------------------------------------------
// msa_ctrl
// Controller for the shared-array stacks: sequences one item at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msa_ctrl
  import msa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire logic out_stall,
  output      logic out_valid,
  input  wire logic cfg_valid,
  output      logic cfg_ready,
  output      msa_cmd_t cmd
);

  msa_state_t state;
  msa_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command outputs; reset keeps every channel closed.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cfg_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_stall   = rst;
        cfg_ready  = !rst;
        cmd.cfg_wr = cfg_valid && !rst;
        cmd.load   = in_valid && !rst;
        if (in_valid && !rst) begin
          state_next = S_BASE;
        end
      end
      S_BASE: begin
        cmd.calc   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = !rst;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/msa_dp.sv
// ---------------------------------------------------------------------------
// msa_dp
// Datapath for the shared-array stacks: layout, top pointers and the store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msa_dp
  import msa_pkg::*;
#(
  parameter int STORE_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire msa_cmd_t                   cmd,
  input  wire logic [NUM_W-1:0]           num_stacks,
  input  wire logic                       func,
  input  wire logic [STK_W-1:0]           stack_index,
  input  wire logic signed [WORD_W-1:0]   push_value,
  output      logic [STATUS_W-1:0]        status,
  output      logic signed [WORD_W-1:0]   pop_value
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = AW + 1;
  localparam int SW = $clog2(STORE_DEPTH + 1);
  localparam int MW = SW + STK_W;
  localparam logic signed [PW-1:0] LAST_POS = PW'(STORE_DEPTH - 1);
  localparam logic signed [PW-1:0] ONE_POS  = PW'(1);

  // Segment size for each stack count, fixed at elaboration.
  logic [SW-1:0] seg_tab [MAX_STACKS];
  for (genvar k = 0; k < MAX_STACKS; k++) begin : g_seg
    localparam int SegK = STORE_DEPTH / (k + 1);
    assign seg_tab[k] = SW'(SegK);
  end

  // Layout registers.
  logic [NUM_W-1:0] n_cnt;
  logic [SW-1:0]    seg;
  logic [NUM_W-1:0] cfg_n;

  // Per-stack tops; a stack whose valid bit is clear sits at its empty base.
  logic signed [PW-1:0] top_pos [MAX_STACKS];
  logic [MAX_STACKS-1:0] top_valid;

  // Item registers.
  logic                 func_r;
  logic [STK_W-1:0]     idx_r;
  logic [WORD_W-1:0]    val_r;

  // Base stage registers.
  logic signed [PW-1:0] base_lo;
  logic signed [PW-1:0] base_hi;
  logic signed [PW-1:0] top_cur;
  logic                 invalid;

  // Result registers.
  logic                 pop_ok;
  logic [WORD_W-1:0]    rd_data;

  logic [MW-1:0]        prod;
  logic signed [PW-1:0] base_lo_c;
  logic signed [PW-1:0] base_hi_c;
  logic                 last_stack;
  logic                 full;
  logic                 empty;
  logic                 do_push;
  logic                 do_pop;
  logic signed [PW-1:0] top_inc;
  logic signed [PW-1:0] top_dec;
  logic [STATUS_W-1:0]  status_next;

  // Clamp the written stack count into one to the maximum.
  always_comb begin
    if (num_stacks == '0) begin
      cfg_n = NUM_W'(1);
    end else if (num_stacks > NUM_W'(MAX_STACKS)) begin
      cfg_n = NUM_W'(MAX_STACKS);
    end else begin
      cfg_n = num_stacks;
    end
  end

  // Layout registers; reset holds one stack over the whole store.
  always_ff @(posedge clk) begin
    if (rst) begin
      n_cnt <= NUM_W'(1);
      seg   <= SW'(STORE_DEPTH);
    end else if (cmd.cfg_wr) begin
      n_cnt <= cfg_n;
      seg   <= seg_tab[STK_W'(cfg_n - NUM_W'(1))];
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      idx_r  <= stack_index;
      val_r  <= push_value;
    end
  end

  // Segment bases of the addressed stack and the one above it.
  assign prod       = MW'(seg) * MW'(idx_r);
  assign base_lo_c  = $signed(prod[PW-1:0]) - ONE_POS;
  assign last_stack = (NUM_W'(idx_r) + NUM_W'(1)) == n_cnt;
  assign base_hi_c  = last_stack ? LAST_POS : (base_lo_c + $signed(PW'(seg)));

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      base_lo <= base_lo_c;
      base_hi <= base_hi_c;
      top_cur <= top_valid[idx_r] ? top_pos[idx_r] : base_lo_c;
      invalid <= NUM_W'(idx_r) >= n_cnt;
    end
  end

  // Decide the outcome of the item.
  assign full    = (top_cur == base_hi) || (top_cur >= LAST_POS);
  assign empty   = (top_cur == base_lo);
  assign top_inc = top_cur + ONE_POS;
  assign top_dec = top_cur - ONE_POS;
  assign do_push = cmd.exec && !invalid && (func_r == FUNC_PUSH) && !full;
  assign do_pop  = cmd.exec && !invalid && (func_r == FUNC_POP) && !empty;

  always_comb begin
    if (invalid) begin
      status_next = STATUS_INVALID;
    end else if (func_r == FUNC_PUSH) begin
      status_next = full ? STATUS_FULL : STATUS_OK;
    end else begin
      status_next = empty ? STATUS_EMPTY : STATUS_OK;
    end
  end

  // Top valid bits are control state and clear on reset or a new layout.
  always_ff @(posedge clk) begin
    if (rst || cmd.cfg_wr) begin
      top_valid <= '0;
    end else if (do_push || do_pop) begin
      top_valid[idx_r] <= 1'b1;
    end
  end

  // Top pointer update.
  always_ff @(posedge clk) begin
    if (do_push) begin
      top_pos[idx_r] <= top_inc;
    end else if (do_pop) begin
      top_pos[idx_r] <= top_dec;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= status_next;
      pop_ok <= do_pop;
    end
  end

  // Word store.
  msa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (top_inc[AW-1:0]),
    .wr_data (val_r),
    .rd_en   (do_pop),
    .rd_addr (top_cur[AW-1:0]),
    .rd_data (rd_data)
  );

  // Popped word, or zero for every other outcome.
  assign pop_value = pop_ok ? $signed(rd_data) : '0;

endmodule

`default_nettype wire

// File: sv/multi_stack_shared_array.sv
// ---------------------------------------------------------------------------
// multi_stack_shared_array
// Several stacks sharing one word store split into equal segments, the last taking any remainder.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    func, stack_index, push_value
//  out      out_valid / out_stall  status, pop_value
//  cfg      cfg_valid / cfg_ready  num_stacks
//
// An item passes through the controller states in turn: capture, base
// multiply, store access, result. Its result is offered in S_OUT, after the
// base and store-access states, and the next item can be accepted in the cycle
// after the result is taken, so the block takes no new item before the last
// result is through. The separate base stage and the registered read of the
// word RAM set the length of this sequence. A pending result holds the input
// and configuration closed until it leaves, also while the output is stalled.
// Reset keeps all channels closed and leaves one stack over the whole store,
// empty; a stack count write empties every stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_stack_shared_array_defines.svh"

module multi_stack_shared_array
  import msa_pkg::*;
#(
  parameter int STORE_DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic                     func,
  input  wire logic [STK_W-1:0]         stack_index,
  input  wire logic signed [WORD_W-1:0] push_value,
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [STATUS_W-1:0]      status,
  output      logic signed [WORD_W-1:0] pop_value,
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic [NUM_W-1:0]         num_stacks
);

  msa_cmd_t cmd;

  // Sequencer.
  msa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Layout, pointers and store.
  msa_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .num_stacks  (num_stacks),
    .func        (func),
    .stack_index (stack_index),
    .push_value  (push_value),
    .status      (status),
    .pop_value   (pop_value)
  );

  // Only a successful pop returns a nonzero word.
  `MSA_ASSERT_SAME(a_value_zero, clk, rst, out_valid && (status != STATUS_OK), pop_value == '0, "pop_value nonzero without ok status")
  // An accepted item closes the input until its result is taken.
  `MSA_ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall && !out_valid, "input open while an item is in flight")
  // A pending result keeps the input and configuration closed.
  `MSA_ASSERT_SAME(a_out_blocks, clk, rst, out_valid, in_stall && !cfg_ready, "input open while a result is pending")
  // A taken result reopens the input in the following cycle.
  `MSA_ASSERT_NEXT(a_reopen, clk, rst, out_valid && !out_stall, !in_stall && !out_valid, "input not reopened after result")

endmodule

`default_nettype wire
